/* rtl/kei_pkg.sv */
// ----------------------------------------------------------------------------
// kei_pkg
// Shared types, codes and constants of the keyframe easing interpolator.
// ----------------------------------------------------------------------------
package kei_pkg;

    localparam int MaxKeys   = 8;
    localparam int MaxAttrs  = 8;
    localparam int FracBits  = 16;
    localparam int KeyW      = $clog2(MaxKeys);
    localparam int AttrW     = $clog2(MaxAttrs);
    localparam int TrackAw   = KeyW + AttrW;
    localparam int TrackDepth = MaxKeys * MaxAttrs;

    localparam logic [FracBits:0] One  = (FracBits + 1)'(1) << FracBits;
    localparam logic [FracBits:0] Half = (FracBits + 1)'(1) << (FracBits - 1);

    typedef enum logic [1:0] {
        OP_EVAL  = 2'd0,
        OP_KEY   = 2'd1,
        OP_TRACK = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [2:0] EASE_CONST  = 3'd0;
    localparam logic [2:0] EASE_LINEAR = 3'd1;
    localparam logic [2:0] EASE_IN     = 3'd2;
    localparam logic [2:0] EASE_OUT    = 3'd3;
    localparam logic [2:0] EASE_INOUT  = 3'd4;

    localparam logic [1:0] REG_DELAY  = 2'd0;
    localparam logic [1:0] REG_KCOUNT = 2'd1;
    localparam logic [1:0] REG_ACOUNT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP0,
        ST_CLAMP1,
        ST_SRCH,
        ST_FRAC,
        ST_DIV,
        ST_RD,
        ST_MEM,
        ST_SQ,
        ST_CB,
        ST_WD,
        ST_SUM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]         ease;
        logic signed [31:0] start_value;
        logic signed [31:0] end_value;
    } t_track;

endpackage

/* rtl/kei_if.sv */
// ----------------------------------------------------------------------------
// kei_in_if / kei_out_if
// Valid/ready channels of the interpolator: command items in, results out.
// ----------------------------------------------------------------------------
interface kei_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] time_value;
    logic [2:0]         key_slot;
    logic [2:0]         attr_slot;
    logic [2:0]         ease_type;
    logic signed [31:0] start_value;
    logic signed [31:0] end_value;

    modport source (output valid, operation, time_value, key_slot, attr_slot, ease_type,
                    start_value, end_value, input ready);
    modport sink (input valid, operation, time_value, key_slot, attr_slot, ease_type,
                  start_value, end_value, output ready);
endinterface

interface kei_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         attr_index;
    logic signed [31:0] attr_value;
    logic               last_result;

    modport source (output valid, attr_index, attr_value, last_result, input ready);
    modport sink (input valid, attr_index, attr_value, last_result, output ready);
endinterface

/* rtl/kei_div.sv */
// ----------------------------------------------------------------------------
// kei_div
// Restoring divider, one quotient bit per cycle, fraction bits of num/den.
// ----------------------------------------------------------------------------
module kei_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [32:0]               i_num,
    input  logic [32:0]               i_den,
    output logic                      o_done,
    output logic [kei_pkg::FracBits-1:0] o_quot
);
    localparam int CntW = $clog2(kei_pkg::FracBits + 1);

    logic [33:0]                   r_rem;
    logic [32:0]                   r_den;
    logic [kei_pkg::FracBits-1:0]  r_q;
    logic [CntW-1:0]               r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [33:0]                   rem2;
    logic                          take;

    assign rem2 = {r_rem[32:0], 1'b0};
    assign take = rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(kei_pkg::FracBits - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= take ? rem2 - {1'b0, r_den} : rem2;
            r_q   <= {r_q[kei_pkg::FracBits-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

/* rtl/kei_mul.sv */
// ----------------------------------------------------------------------------
// kei_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module kei_mul (
    input  logic               i_clk,
    input  logic signed [33:0] i_a,
    input  logic signed [17:0] i_b,
    output logic signed [51:0] o_prod
);
    logic signed [51:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

/* rtl/kei_track_mem.sv */
// ----------------------------------------------------------------------------
// kei_track_mem
// Track entry memory with per-entry valid bits; unwritten entries read zero.
// ----------------------------------------------------------------------------
module kei_track_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [kei_pkg::TrackAw-1:0]   i_waddr,
    input  kei_pkg::t_track               i_wdata,
    input  logic                          i_re,
    input  logic [kei_pkg::TrackAw-1:0]   i_raddr,
    output kei_pkg::t_track               o_rdata
);
    kei_pkg::t_track                   mem [kei_pkg::TrackDepth];
    logic [kei_pkg::TrackDepth-1:0]    r_valid;
    kei_pkg::t_track                   r_rdata;
    logic                              r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;
endmodule

/* rtl/keyframe_easing_interpolator.sv */
// ----------------------------------------------------------------------------
// keyframe_easing_interpolator
// Keyframe table, per-segment const/linear/cubic easing, Q16.16 per attribute.
// ----------------------------------------------------------------------------
// Usage:
//   i_in takes command items: write keyframe time, write track entry, or
//   evaluate at a time. Writes produce no results.
//   An evaluate item yields attribute_count result items on o_out, the last
//   one flagged by last_result.
//   An evaluate goes through clamping to the first and last keyframe time,
//   a segment search (one keyframe read per cycle), a setup step, the serial
//   fraction divider when the time is inside a segment, then per attribute
//   the shared multiplier (square, cube, scale), plus any stall on o_out.
//   i_in.ready is low until the last result is taken. A stalled receiver
//   holds the block in place with the result steady.
//   Registers (APB): 0 time_delay, 1 keyframe_count, 2 attribute_count;
//   reset to 0, 2 and 1. Reset also zeroes keyframe times and track entries.
// ----------------------------------------------------------------------------
module keyframe_easing_interpolator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kei_in_if.sink      i_in,
    kei_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int Fb = kei_pkg::FracBits;
    localparam int Kw = kei_pkg::KeyW;
    localparam int Aw = kei_pkg::AttrW;

    kei_pkg::t_state    r_state, n_state;
    logic signed [31:0] r_delay;
    logic [3:0]         r_kcount;
    logic [3:0]         r_acount;
    logic signed [31:0] r_kt [kei_pkg::MaxKeys];

    logic signed [32:0] r_t;
    logic [Kw-1:0]      r_k;
    logic               r_lo;
    logic signed [31:0] r_prev;
    logic signed [31:0] r_s;
    logic signed [31:0] r_e;
    logic [Kw-1:0]      r_seg;
    logic [Fb:0]        r_f;
    logic [Aw-1:0]      r_attr;
    logic [2:0]         r_type;
    logic signed [31:0] r_sv;
    logic signed [32:0] r_delta;
    logic [Fb:0]        r_g;
    logic [2:0]         r_out_idx;
    logic signed [31:0] r_out_val;
    logic               r_out_last;

    logic               in_acc;
    logic               cfg_wr;
    logic [3:0]         kc_eff;
    logic [3:0]         ac_eff;
    logic [Kw-1:0]      kc_last;
    logic [Aw-1:0]      ac_last;
    logic [Kw-1:0]      kt_idx;
    logic signed [31:0] kt_rd;
    logic signed [32:0] kt_rd33;
    logic               hit;
    logic signed [33:0] num;
    logic signed [33:0] den;
    logic               div_start;
    logic               div_done;
    logic [Fb-1:0]      div_quot;
    logic               mem_re;
    kei_pkg::t_track    mem_wdata;
    kei_pkg::t_track    mem_rdata;
    logic               inv;
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [51:0] prod;
    logic [Fb:0]        cube;
    logic [Fb+2:0]      cube4;
    logic [Fb:0]        w_val;
    logic signed [35:0] scaled;
    logic signed [36:0] sum;
    logic signed [31:0] sat;

    assign in_acc = i_in.valid && i_in.ready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            kei_pkg::REG_DELAY:  prdata = r_delay;
            kei_pkg::REG_KCOUNT: prdata = {28'd0, r_kcount};
            kei_pkg::REG_ACOUNT: prdata = {28'd0, r_acount};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= '0;
            r_kcount <= 4'd2;
            r_acount <= 4'd1;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                kei_pkg::REG_DELAY:  r_delay  <= pwdata;
                kei_pkg::REG_KCOUNT: r_kcount <= pwdata[3:0];
                kei_pkg::REG_ACOUNT: r_acount <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    assign kc_eff  = (r_kcount < 4'd2) ? 4'd2 :
                     (r_kcount > 4'(kei_pkg::MaxKeys)) ? 4'(kei_pkg::MaxKeys) : r_kcount;
    assign ac_eff  = (r_acount == 4'd0) ? 4'd1 :
                     (r_acount > 4'(kei_pkg::MaxAttrs)) ? 4'(kei_pkg::MaxAttrs) : r_acount;
    assign kc_last = Kw'(kc_eff - 4'd1);
    assign ac_last = Aw'(ac_eff - 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < kei_pkg::MaxKeys; i++) begin
                r_kt[i] <= '0;
            end
        end else if (in_acc && i_in.operation == kei_pkg::OP_KEY) begin
            r_kt[i_in.key_slot] <= i_in.time_value;
        end
    end

    assign mem_wdata = '{ease: i_in.ease_type, start_value: i_in.start_value,
                         end_value: i_in.end_value};

    kei_track_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (in_acc && i_in.operation == kei_pkg::OP_TRACK),
        .i_waddr ({i_in.key_slot, i_in.attr_slot}),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr ({r_seg, r_attr}),
        .o_rdata (mem_rdata)
    );

    kei_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num[32:0]),
        .i_den   (den[32:0]),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    kei_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign kt_rd   = r_kt[kt_idx];
    assign kt_rd33 = 33'(kt_rd);
    assign hit     = (r_k != '0) && r_lo && (r_t <= kt_rd33);
    assign num     = 34'(r_t) - 34'(r_s);
    assign den     = 34'(r_e) - 34'(r_s);

    assign inv   = (mem_rdata.ease == kei_pkg::EASE_OUT) ||
                   (mem_rdata.ease == kei_pkg::EASE_INOUT && r_f >= kei_pkg::Half);
    assign cube  = prod[2*Fb:Fb];
    assign cube4 = {cube, 2'b00};

    always_comb begin
        case (r_type)
            kei_pkg::EASE_LINEAR: w_val = r_f;
            kei_pkg::EASE_IN:     w_val = cube;
            kei_pkg::EASE_OUT:    w_val = kei_pkg::One - cube;
            kei_pkg::EASE_INOUT:  w_val = (r_f < kei_pkg::Half) ? cube4[Fb:0]
                                                                : kei_pkg::One - cube4[Fb:0];
            default:              w_val = '0;
        endcase
    end

    assign scaled = prod[51:Fb];
    assign sum    = 37'(r_sv) + 37'(scaled);
    assign sat    = (sum > 37'sd2147483647) ? 32'sh7fffffff :
                    (sum < -37'sd2147483648) ? 32'sh80000000 : sum[31:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kei_pkg::ST_IDLE:   if (in_acc && i_in.operation == kei_pkg::OP_EVAL) begin
                                    n_state = kei_pkg::ST_CLAMP0;
                                end
            kei_pkg::ST_CLAMP0: n_state = (r_t < kt_rd33) ? kei_pkg::ST_SRCH
                                                          : kei_pkg::ST_CLAMP1;
            kei_pkg::ST_CLAMP1: n_state = kei_pkg::ST_SRCH;
            kei_pkg::ST_SRCH:   if (hit || r_k == kc_last) begin
                                    n_state = kei_pkg::ST_FRAC;
                                end
            kei_pkg::ST_FRAC:   n_state = (den <= 0 || num <= 0 || num >= den)
                                          ? kei_pkg::ST_RD : kei_pkg::ST_DIV;
            kei_pkg::ST_DIV:    if (div_done) begin
                                    n_state = kei_pkg::ST_RD;
                                end
            kei_pkg::ST_RD:     n_state = kei_pkg::ST_MEM;
            kei_pkg::ST_MEM:    n_state = kei_pkg::ST_SQ;
            kei_pkg::ST_SQ:     n_state = kei_pkg::ST_CB;
            kei_pkg::ST_CB:     n_state = kei_pkg::ST_WD;
            kei_pkg::ST_WD:     n_state = kei_pkg::ST_SUM;
            kei_pkg::ST_SUM:    n_state = kei_pkg::ST_OUT;
            kei_pkg::ST_OUT:    if (o_out.ready) begin
                                    n_state = (r_attr == ac_last) ? kei_pkg::ST_IDLE
                                                                  : kei_pkg::ST_RD;
                                end
            default:            n_state = kei_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = (r_state == kei_pkg::ST_IDLE);
        o_out.valid = (r_state == kei_pkg::ST_OUT);
        div_start = 1'b0;
        mem_re    = 1'b0;
        kt_idx    = r_k;
        mul_a     = 34'(r_g);
        mul_b     = 18'(r_g);
        unique case (r_state)
            kei_pkg::ST_CLAMP0: kt_idx = '0;
            kei_pkg::ST_CLAMP1: kt_idx = kc_last;
            kei_pkg::ST_FRAC:   div_start = !(den <= 0 || num <= 0 || num >= den);
            kei_pkg::ST_RD:     mem_re = 1'b1;
            kei_pkg::ST_CB:     mul_a = 34'(prod[2*Fb:Fb]);
            kei_pkg::ST_WD: begin
                mul_a = 34'(r_delta);
                mul_b = 18'(w_val);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kei_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            kei_pkg::ST_IDLE: begin
                r_t    <= 33'(i_in.time_value) - 33'(r_delay);
                r_k    <= '0;
                r_lo   <= 1'b0;
                r_attr <= '0;
            end
            kei_pkg::ST_CLAMP0: if (r_t < kt_rd33) begin
                r_t <= kt_rd33;
            end
            kei_pkg::ST_CLAMP1: if (r_t > kt_rd33) begin
                r_t <= kt_rd33;
            end
            kei_pkg::ST_SRCH: begin
                if (hit || r_k == kc_last) begin
                    r_seg <= r_k - 1'b1;
                    r_s   <= r_prev;
                    r_e   <= kt_rd;
                end else begin
                    r_lo   <= (kt_rd33 <= r_t);
                    r_prev <= kt_rd;
                    r_k    <= r_k + 1'b1;
                end
            end
            kei_pkg::ST_FRAC: begin
                if (den <= 0 || num <= 0) begin
                    r_f <= '0;
                end else begin
                    r_f <= kei_pkg::One;
                end
            end
            kei_pkg::ST_DIV: if (div_done) begin
                r_f <= {1'b0, div_quot};
            end
            kei_pkg::ST_MEM: begin
                r_type  <= mem_rdata.ease;
                r_sv    <= mem_rdata.start_value;
                r_delta <= 33'(mem_rdata.end_value) - 33'(mem_rdata.start_value);
                r_g     <= inv ? kei_pkg::One - r_f : r_f;
            end
            kei_pkg::ST_SUM: begin
                r_out_idx  <= 3'(r_attr);
                r_out_val  <= sat;
                r_out_last <= (r_attr == ac_last);
            end
            kei_pkg::ST_OUT: if (o_out.ready) begin
                r_attr <= r_attr + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_out.attr_index  = r_out_idx;
    assign o_out.attr_value  = r_out_val;
    assign o_out.last_result = r_out_last;
endmodule
